// ===== design/btkrl_pkg.sv =====
// shared types and constants of the bounded top-k rank list
`timescale 1ns / 1ps

package btkrl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int ID_W         = 31;
    localparam int VAL_W        = 32;
    localparam int OP_W         = 2;
    localparam int DCNT_W       = 5;
    localparam int RANK_W       = 5;
    localparam int CFG_W        = 5;
    localparam int EXT_W        = 8;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DUMP   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic head;
        logic load_sh;
        logic shift_sh;
    } t_cell_ctrl;

endpackage

// ===== design/btkrl_cell.sv =====
// one cell of the rank chain: an entry, its insert decision and a dump shadow
`timescale 1ns / 1ps

module btkrl_cell import btkrl_pkg::*; (
    input  logic                    i_clk,
    input  t_cell_ctrl              i_ctrl,
    input  logic                    i_lead,
    input  logic                    i_occ,
    input  logic [ID_W-1:0]         i_new_id,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic [ID_W-1:0]         i_prev_id,
    input  logic signed [VAL_W-1:0] i_prev_value,
    input  logic                    i_prev_lt,
    input  logic [ID_W-1:0]         i_below_shadow,
    output logic [ID_W-1:0]         o_id,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_lt,
    output logic                    o_lt_occ,
    output logic                    o_match,
    output logic [ID_W-1:0]         o_shadow
);

    logic [ID_W-1:0]         r_id;
    logic signed [VAL_W-1:0] r_value;
    logic [ID_W-1:0]         r_shadow;
    logic                    w_ins_here;
    logic                    w_take_prev;

    assign o_lt_occ = i_occ && (r_value < i_new_value);
    assign o_lt     = !i_occ || o_lt_occ;
    assign o_match  = i_occ && (r_id == i_new_id);

    // new pair lands at the first cell below the new value, or at the front
    assign w_ins_here  = (i_lead && i_ctrl.head) || (!i_ctrl.head && o_lt && !i_prev_lt);
    assign w_take_prev = i_ctrl.head || i_prev_lt;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en) begin
            if (w_ins_here) begin
                r_id    <= i_new_id;
                r_value <= i_new_value;
            end else if (w_take_prev) begin
                r_id    <= i_prev_id;
                r_value <= i_prev_value;
            end
        end
        if (i_ctrl.load_sh) begin
            r_shadow <= r_id;
        end else if (i_ctrl.shift_sh) begin
            r_shadow <= i_below_shadow;
        end
    end

    assign o_id     = r_id;
    assign o_value  = r_value;
    assign o_shadow = r_shadow;

endmodule

// ===== design/bounded_top_k_rank_list_top.sv =====
// top level of the bounded top-k rank list: cell chain, sequencer and result register
`timescale 1ns / 1ps

// usage
//   input channel (i_valid / o_ready) carries one word: opcode, id, value, dump count
//   result channel (o_res_valid / i_res_ready) carries accepted, rank, id, out_valid, last
//   config channel (i_cfg_valid / o_cfg_ready) writes max_entries, always ready
// sequencing and throughput
//   insert: result registered at acceptance, one insert per cycle while results drain
//   find: match vector registered, rank encoded in the next cycle; no word is taken meanwhile
//   dump of m ids: ids copied into the shadow chain, then one id per cycle while results drain;
//   an empty dump answers with a single word; opcode 3 is taken and answers nothing
//   the rate is set by the single result register and the shadow chain shifting
//   one cell a cycle toward the head
// reset
//   synchronous, active low: list empty, limit 16, no result pending
// stalls
//   a waiting result holds the result register; new words are refused until it
//   is taken, dumps simply pause and resume

module bounded_top_k_rank_list_top import btkrl_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [ID_W-1:0]         i_item_id,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic [DCNT_W-1:0]       i_dump_count,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output logic                    o_accepted,
    output logic [RANK_W-1:0]       o_rank,
    output logic [ID_W-1:0]         o_out_id,
    output logic                    o_out_valid,
    output logic                    o_last,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FIND = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    // control state
    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CFG_W-1:0]   r_max_entries;
    logic               r_res_valid;
    logic [RANK_W-1:0]  r_left;
    logic [RANK_W-1:0]  r_didx;

    // result word and find vector
    logic               r_accepted;
    logic [RANK_W-1:0]  r_rank;
    logic [ID_W-1:0]    r_out_id;
    logic               r_out_valid;
    logic               r_last;
    logic [CAPACITY-1:0] r_match;

    // chain wiring
    logic [ID_W-1:0]         w_id     [CAPACITY];
    logic signed [VAL_W-1:0] w_value  [CAPACITY];
    logic [ID_W-1:0]         w_shadow [CAPACITY];
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_lt_occ;
    logic [CAPACITY-1:0]     w_match;
    t_cell_ctrl              w_ctrl;

    logic               w_can_load;
    logic               w_in_acc;
    t_opcode            w_op;
    logic [EXT_W-1:0]   w_n8;
    logic [EXT_W-1:0]   w_lim8;
    logic [EXT_W-1:0]   w_n1;
    logic [EXT_W-1:0]   w_m8;
    logic [RANK_W-1:0]  w_m;
    logic               w_reject;
    logic               w_ins_ok;
    logic [CW-1:0]      n_count;
    logic [CAPACITY-1:0] w_iso;
    logic [RANK_W-1:0]  w_find_rank;
    logic               w_res_load;

    assign w_can_load  = !r_res_valid || i_res_ready;
    assign o_ready     = (r_state == S_IDLE) && w_can_load;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && o_ready;
    assign w_op        = t_opcode'(i_opcode);

    // limit: zero acts as one, clipped to the capacity
    assign w_n8 = EXT_W'(r_count);
    always_comb begin
        if (r_max_entries == '0) begin
            w_lim8 = EXT_W'(1);
        end else if (EXT_W'(r_max_entries) > EXT_W'(CAPACITY)) begin
            w_lim8 = EXT_W'(CAPACITY);
        end else begin
            w_lim8 = EXT_W'(r_max_entries);
        end
    end

    // not above the tail means no held entry is below the new value
    assign w_reject = !(|w_lt_occ) && (w_n8 >= w_lim8);
    assign w_ins_ok = w_in_acc && (w_op == OP_INSERT) && !w_reject;
    assign w_n1     = w_n8 + EXT_W'(1);
    assign n_count  = (w_n1 > w_lim8) ? CW'(w_lim8) : CW'(w_n1);

    // dump length: min of request, count and result limit
    always_comb begin
        w_m8 = EXT_W'(i_dump_count);
        if (w_n8 < w_m8) begin
            w_m8 = w_n8;
        end
        if (w_m8 > EXT_W'(MAX_RESULTS)) begin
            w_m8 = EXT_W'(MAX_RESULTS);
        end
    end
    assign w_m = RANK_W'(w_m8);

    // in a non-empty list the front is taken only by a value above the tail and not below the head
    always_comb begin
        w_ctrl.ins_en   = w_ins_ok;
        w_ctrl.head     = (r_count != '0) && (|w_lt_occ) && (i_item_value >= w_value[0]);
        w_ctrl.load_sh  = w_in_acc && (w_op == OP_DUMP);
        w_ctrl.shift_sh = (r_state == S_DUMP) && w_can_load;
    end

    // result register loads on an insert, an empty dump, a find answer or a dump id
    assign w_res_load = (w_in_acc && ((w_op == OP_INSERT) ||
                                      ((w_op == OP_DUMP) && (w_m == '0)))) ||
                        ((r_state inside {S_FIND, S_DUMP}) && w_can_load);

    // the cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ID_W-1:0]         w_pid;
        logic signed [VAL_W-1:0] w_pval;
        logic                    w_plt;
        logic [ID_W-1:0]         w_bsh;
        if (g == 0) begin : g_first
            assign w_pid  = '0;
            assign w_pval = '0;
            assign w_plt  = 1'b0;
        end else begin : g_rest
            assign w_pid  = w_id[g-1];
            assign w_pval = w_value[g-1];
            assign w_plt  = w_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_bsh = '0;
        end else begin : g_inner
            assign w_bsh = w_shadow[g+1];
        end
        btkrl_cell u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (w_ctrl),
            .i_lead         (g == 0),
            .i_occ          (r_count > CW'(g)),
            .i_new_id       (i_item_id),
            .i_new_value    (i_item_value),
            .i_prev_id      (w_pid),
            .i_prev_value   (w_pval),
            .i_prev_lt      (w_plt),
            .i_below_shadow (w_bsh),
            .o_id           (w_id[g]),
            .o_value        (w_value[g]),
            .o_lt           (w_lt[g]),
            .o_lt_occ       (w_lt_occ[g]),
            .o_match        (w_match[g]),
            .o_shadow       (w_shadow[g])
        );
    end

    // first match isolated, then encoded as a 1-based rank
    assign w_iso = r_match & (~r_match + CAPACITY'(1));
    always_comb begin
        w_find_rank = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_find_rank = w_find_rank | ({RANK_W{w_iso[i]}} & RANK_W'(i + 1));
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_max_entries <= MAX_ENTRIES_RST;
            r_res_valid   <= 1'b0;
            r_left        <= '0;
            r_didx        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_entries <= i_cfg_data;
            end
            if (w_res_load) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (w_ins_ok) begin
                r_count <= n_count;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (w_op)
                            OP_INSERT: begin
                                r_accepted  <= !w_reject;
                                r_rank      <= '0;
                                r_out_id    <= '0;
                                r_out_valid <= 1'b0;
                                r_last      <= 1'b1;
                            end
                            OP_FIND: begin
                                r_match <= w_match;
                                r_state <= S_FIND;
                            end
                            OP_DUMP: begin
                                if (w_m == '0) begin
                                    r_accepted  <= 1'b0;
                                    r_rank      <= '0;
                                    r_out_id    <= '0;
                                    r_out_valid <= 1'b0;
                                    r_last      <= 1'b1;
                                end else begin
                                    r_left  <= w_m;
                                    r_didx  <= RANK_W'(1);
                                    r_state <= S_DUMP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    if (w_can_load) begin
                        r_accepted  <= 1'b0;
                        r_rank      <= w_find_rank;
                        r_out_id    <= '0;
                        r_out_valid <= 1'b0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (w_can_load) begin
                        r_accepted  <= 1'b0;
                        r_rank      <= r_didx;
                        r_out_id    <= w_shadow[0];
                        r_out_valid <= 1'b1;
                        r_last      <= (r_left == RANK_W'(1));
                        r_didx      <= r_didx + RANK_W'(1);
                        r_left      <= r_left - RANK_W'(1);
                        if (r_left == RANK_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_accepted  = r_accepted;
    assign o_rank      = r_rank;
    assign o_out_id    = r_out_id;
    assign o_out_valid = r_out_valid;
    assign o_last      = r_last;

`ifndef NO_ASSERTIONS
    // the fill count never passes the number of cells
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // an insert answers with a single final word in the next cycle
    a_insert_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_op == OP_INSERT)) |=> (o_res_valid && o_last && (o_rank == '0)))
        else $error("insert reply missing or malformed");

    // a dump in progress always has ids left to send
    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_left != '0))
        else $error("dump running with nothing left");
`endif

endmodule

// ===== dv/rank_list_checker.sv =====
// checker of the rank list: shadow list, expected replies and comparison
`timescale 1ns / 1ps

module rank_list_checker import btkrl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_word_valid,
    input  logic                    i_word_ready,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [ID_W-1:0]         i_item_id,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic [DCNT_W-1:0]       i_dump_count,
    input  logic                    i_res_valid,
    input  logic                    i_res_ready,
    input  logic                    i_accepted,
    input  logic [RANK_W-1:0]       i_rank,
    input  logic [ID_W-1:0]         i_out_id,
    input  logic                    i_out_valid,
    input  logic                    i_last,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_replies_due
);

    typedef struct packed {
        logic              accepted;
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   out_id;
        logic              out_valid;
        logic              last;
    } t_list_reply;

    // shadow copy of the ranked list
    logic [ID_W-1:0]         shadow_ids  [CAPACITY_DEF];
    logic signed [VAL_W-1:0] shadow_vals [CAPACITY_DEF];
    int                      shadow_len;
    logic [CFG_W-1:0]        max_entries;

    t_list_reply replies_due[$];

    function automatic int limit_in_force();
        int lim;
        lim = int'(max_entries);
        if (lim == 0) lim = 1;
        if (lim > CAPACITY_DEF) lim = CAPACITY_DEF;
        return lim;
    endfunction

    // places one pair by value, 1 when stored
    function automatic logic place_pair(input logic [ID_W-1:0] id,
                                        input logic signed [VAL_W-1:0] val);
        int lim;
        int n;
        int pos;
        int j;
        lim = limit_in_force();
        n   = shadow_len;
        pos = 0;
        if (n == 0) begin
            pos = 0;
        end else if (val <= shadow_vals[n-1]) begin
            if (n >= lim) return 1'b0;
            pos = n;
        end else if (val >= shadow_vals[0]) begin
            pos = 0;
        end else begin
            while (pos < n && shadow_vals[pos] >= val) pos++;
        end
        j = (n < CAPACITY_DEF) ? n : CAPACITY_DEF - 1;
        while (j > pos) begin
            shadow_ids[j]  = shadow_ids[j-1];
            shadow_vals[j] = shadow_vals[j-1];
            j--;
        end
        if (pos < CAPACITY_DEF) begin
            shadow_ids[pos]  = id;
            shadow_vals[pos] = val;
        end
        n = n + 1;
        if (n > CAPACITY_DEF) n = CAPACITY_DEF;
        if (n > lim) n = lim;
        shadow_len = n;
        return 1'b1;
    endfunction

    function automatic t_list_reply make_reply(input logic acc, input int rank,
                                               input logic [ID_W-1:0] id,
                                               input logic ov, input logic fin);
        t_list_reply r;
        r.accepted  = acc;
        r.rank      = RANK_W'(rank);
        r.out_id    = id;
        r.out_valid = ov;
        r.last      = fin;
        return r;
    endfunction

    // one expected reply joins the back of the queue
    function automatic void queue_reply(input t_list_reply r);
        replies_due.insert(replies_due.size(), r);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_reply want;
        int          m;
        int          k;
        int          hit;
        if (!i_rst_n) begin
            o_fail_count = 0;
            shadow_len   = 0;
            max_entries  = MAX_ENTRIES_RST;
            replies_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) max_entries = i_cfg_data;

            if (i_res_valid && i_res_ready) begin
                if (replies_due.size() == 0) begin
                    $error("reply with none expected: rank %0d id %0d last %0d",
                           i_rank, i_out_id, i_last);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(i_accepted));
                    check_field("rank", 32'(want.rank), 32'(i_rank));
                    check_field("out_id", 32'(want.out_id), 32'(i_out_id));
                    check_field("out_valid", 32'(want.out_valid), 32'(i_out_valid));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end

            if (i_word_valid && i_word_ready) begin
                case (t_opcode'(i_opcode))
                    OP_INSERT: begin
                        queue_reply(make_reply(place_pair(i_item_id, i_item_value),
                                               0, '0, 1'b0, 1'b1));
                    end
                    OP_FIND: begin
                        hit = 0;
                        for (k = 0; k < shadow_len; k++) begin
                            if (hit == 0 && shadow_ids[k] == i_item_id) hit = k + 1;
                        end
                        queue_reply(make_reply(1'b0, hit, '0, 1'b0, 1'b1));
                    end
                    OP_DUMP: begin
                        m = int'(i_dump_count);
                        if (m > shadow_len) m = shadow_len;
                        if (m > MAX_RESULTS) m = MAX_RESULTS;
                        if (m == 0) begin
                            queue_reply(make_reply(1'b0, 0, '0, 1'b0, 1'b1));
                        end else begin
                            for (k = 0; k < m; k++) begin
                                queue_reply(make_reply(1'b0, k + 1, shadow_ids[k],
                                                       1'b1, k == m - 1));
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_replies_due = replies_due.size();
    end

endmodule

// ===== dv/tb_bounded_top_k_rank_list_top.sv =====
// testbench top of the rank list: stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 1ps

module tb_bounded_top_k_rank_list_top;
    import btkrl_pkg::*;

    // no handshake of any kind for this many cycles ends the run
    localparam int WATCHDOG_LIMIT = 3000;
    // long receiver hold-off so the result register and the input back up
    localparam int HOLD_CYCLES    = 80;
    // quiet cycles after the last reply, covers a no-op still in flight
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_WORDS    = 26;

    logic                    clk;
    logic                    rst_n;
    logic                    word_valid;
    logic                    word_ready;
    logic [OP_W-1:0]         opcode;
    logic [ID_W-1:0]         item_id;
    logic signed [VAL_W-1:0] item_value;
    logic [DCNT_W-1:0]       dump_count;
    logic                    res_valid;
    logic                    res_ready;
    logic                    res_accepted;
    logic [RANK_W-1:0]       res_rank;
    logic [ID_W-1:0]         res_id;
    logic                    res_out_valid;
    logic                    res_last;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data;

    int fail_count;
    int replies_due;
    int stall_cycles = 0;

    // gaps_on lets both sides idle at random; hold_go asks the receiver for one long hold
    bit gaps_on = 1'b1;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;

    bounded_top_k_rank_list_top #(
        .CAPACITY(CAPACITY_DEF)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (word_valid),
        .o_ready     (word_ready),
        .i_opcode    (opcode),
        .i_item_id   (item_id),
        .i_item_value(item_value),
        .i_dump_count(dump_count),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_accepted  (res_accepted),
        .o_rank      (res_rank),
        .o_out_id    (res_id),
        .o_out_valid (res_out_valid),
        .o_last      (res_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    rank_list_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_word_valid (word_valid),
        .i_word_ready (word_ready),
        .i_opcode     (opcode),
        .i_item_id    (item_id),
        .i_item_value (item_value),
        .i_dump_count (dump_count),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_accepted   (res_accepted),
        .i_rank       (res_rank),
        .i_out_id     (res_id),
        .i_out_valid  (res_out_valid),
        .i_last       (res_last),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_replies_due(replies_due)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // offers one word and returns at the edge that accepts it; valid stays up on return
    // so back-to-back words drop valid in between only when gaps_on inserts a random gap
    task automatic send_word(input t_opcode op, input logic [ID_W-1:0] id,
                             input logic signed [VAL_W-1:0] val,
                             input logic [DCNT_W-1:0] cnt);
        while (gaps_on && $urandom_range(99) < 19) begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid <= 1'b1;
        opcode     <= op;
        item_id    <= id;
        item_value <= val;
        dump_count <= cnt;
        @(posedge clk);
        while (!word_ready) @(posedge clk);
    endtask

    // limit written only with the list idle: all replies in and a few quiet cycles
    task automatic set_limit(input logic [CFG_W-1:0] lim);
        word_valid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one random word; no-ops are flagged so they are not counted
    task automatic send_random_word(output bit counted);
        t_opcode                 op;
        logic [ID_W-1:0]         id;
        logic signed [VAL_W-1:0] val;
        logic [DCNT_W-1:0]       cnt;
        int                      pick;
        pick = $urandom_range(99);
        if (pick < 50)      op = OP_INSERT;
        else if (pick < 78) op = OP_FIND;
        else if (pick < 95) op = OP_DUMP;
        else                op = OP_NOP;
        // small id pool so finds hit and ids repeat, now and then a full-width id
        if ($urandom_range(3) == 0) id = ID_W'($urandom);
        else                        id = ID_W'($urandom_range(23));
        // coarse value grid gives plenty of ties, plus extremes and full-range noise
        case ($urandom_range(5))
            0:       val = $urandom;
            1:       val = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: val = $signed(32'($urandom_range(8))) * 1000 - 4000;
        endcase
        if ($urandom_range(4) == 0) cnt = DCNT_W'($urandom_range(31));
        else                        cnt = DCNT_W'($urandom_range(6));
        send_word(op, id, val, cnt);
        counted = (op != OP_NOP);
    endtask

    // receiver: random stalls, and one long hold when asked
    initial begin
        res_ready = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    res_ready <= 1'b0;
                    @(posedge clk);
                end
            end else begin
                res_ready <= !gaps_on || ($urandom_range(99) >= 19);
                @(posedge clk);
            end
        end
    end

    // watchdog: cycles in a row with no word, reply or register write taken
    always @(posedge clk) begin
        if ((word_valid && word_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int  phase_limits [8];
        int  p;
        int  sent;
        bit  counted;
        rst_n      = 1'b0;
        word_valid = 1'b0;
        opcode     = OP_NOP;
        item_id    = '0;
        item_value = '0;
        dump_count = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        phase_limits = '{16, 4, 0, 31, 1, 9, 16, 0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: find misses, dump answers with a single empty word
        send_word(OP_FIND,   '0, '0, 5'd0);
        send_word(OP_DUMP,   '0, '0, 5'd5);
        // fill with the field extremes
        send_word(OP_INSERT, 31'h7fff_ffff, 32'sh7fff_ffff, 5'd0);
        send_word(OP_INSERT, 31'd0, 32'sh8000_0000, 5'd0);   // below tail, appended
        send_word(OP_INSERT, 31'd1, 32'sd0, 5'd0);           // between head and tail
        send_word(OP_INSERT, 31'd2, 32'sh7fff_ffff, 5'd0);   // equal to head, to the front
        send_word(OP_INSERT, 31'd3, 32'sh8000_0000, 5'd0);   // equal to tail, appended
        send_word(OP_INSERT, 31'd4, 32'sd0, 5'd0);           // after the equal middle entry
        send_word(OP_FIND,   31'h7fff_ffff, '0, 5'd0);
        send_word(OP_FIND,   31'd12345, '0, 5'd0);           // absent id
        send_word(OP_NOP,    31'd9, 32'sd9, 5'd9);
        send_word(OP_DUMP,   '0, '0, 5'd31);                 // capped at the list length
        send_word(OP_DUMP,   '0, '0, 5'd0);
        send_word(OP_DUMP,   '0, '0, 5'd3);

        // limit lowered under the count: entries stay until the next stored insert
        set_limit(5'd2);
        send_word(OP_INSERT, 31'd5, 32'sh8000_0000, 5'd0);   // not above tail, refused
        send_word(OP_FIND,   31'd3, '0, 5'd0);
        send_word(OP_DUMP,   '0, '0, 5'd16);
        send_word(OP_INSERT, 31'd6, 32'sd1, 5'd0);           // stored, list cut to two
        send_word(OP_DUMP,   '0, '0, 5'd16);

        // zero limit behaves as one
        set_limit(5'd0);
        send_word(OP_INSERT, 31'd8, -32'sd5, 5'd0);
        send_word(OP_INSERT, 31'd9, 32'sh7fff_ffff, 5'd0);
        send_word(OP_DUMP,   '0, '0, 5'd2);

        // limit above capacity behaves as capacity
        set_limit(5'd31);
        send_word(OP_INSERT, 31'd10, 32'sd5, 5'd0);
        send_word(OP_FIND,   31'd10, '0, 5'd0);
        send_word(OP_DUMP,   '0, '0, 5'd31);

        // random phases, each under its own limit; the last limit is drawn at random
        phase_limits[7] = int'($urandom_range(31));
        for (p = 0; p < 8; p++) begin
            set_limit(CFG_W'(phase_limits[p]));
            // phase 6: no idling on either side, plus the long receiver hold
            gaps_on = (p != 6);
            if (p == 6) hold_go = 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                send_random_word(counted);
                if (counted) sent++;
            end
        end
        gaps_on = 1'b1;

        word_valid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && replies_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
